### rtl/core/lsct_pkg.sv
// Shared types and constants for the LRU sector cache tag store.
// Used by lsct_lookup and lru_sector_cache_tags_core; depends on nothing.
package lsct_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int SECTOR_W = 32;
  localparam int SLOT_W   = 4;
  localparam int CAP_W    = 5;
  localparam int OUT_W    = 40;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    FUNC_FETCH = 1'b0,
    FUNC_STORE = 1'b1
  } func_e;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [SECTOR_W-1:0] sector_t;

  // Decision for one transaction: result fields plus the table update.
  typedef struct packed {
    logic    hit;
    idx_t    slot;
    logic    written;
    logic    evicted;
    sector_t ev_sector;
    logic    upd;        // promote slot to most recent
    logic    set_tag;    // load the new sector into slot
    logic    set_valid;  // slot was free, mark it used
    logic    inc_used;
    cnt_t    thresh;     // valid entries ranked below this age by one
  } lookup_t;

endpackage

### rtl/core/lsct_lookup.sv
// Parallel tag compare, victim and free slot search for the sector cache.
// Depends on lsct_pkg.
module lsct_lookup
  import lsct_pkg::*;
(
  input  logic       func_i,
  input  sector_t    sector_i,
  input  sector_t    tags_i  [ENTRIES],
  input  logic       valid_i [ENTRIES],
  input  idx_t       ranks_i [ENTRIES],
  input  cnt_t       used_i,
  input  logic [CAP_W-1:0] cap_i,
  output lookup_t    lookup_o
);

  cnt_t eff_cap;
  logic hit_any, victim_any, free_any;
  idx_t hit_idx, victim_idx, free_idx;
  cnt_t last_rank;

  always_comb begin
    if (int'(cap_i) > ENTRIES) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_i);
    end
  end

  assign last_rank = used_i - cnt_t'(1);

  // Scan downward so the lowest matching slot wins.
  always_comb begin
    hit_any    = 1'b0;
    victim_any = 1'b0;
    free_any   = 1'b0;
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_i[i] && (tags_i[i] == sector_i)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (valid_i[i] && (CNT_W'(ranks_i[i]) == last_rank)) begin
        victim_any = 1'b1;
        victim_idx = IDX_W'(i);
      end
      if (!valid_i[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    lookup_o = '0;
    if (eff_cap != '0) begin
      if (hit_any) begin
        lookup_o.hit     = 1'b1;
        lookup_o.slot    = hit_idx;
        lookup_o.written = (func_i == FUNC_STORE);
        lookup_o.upd     = 1'b1;
        lookup_o.thresh  = CNT_W'(ranks_i[hit_idx]);
      end else if (func_i == FUNC_STORE) begin
        lookup_o.written = 1'b1;
        lookup_o.upd     = 1'b1;
        lookup_o.set_tag = 1'b1;
        if ((used_i >= eff_cap) && victim_any) begin
          lookup_o.evicted   = 1'b1;
          lookup_o.slot      = victim_idx;
          lookup_o.ev_sector = tags_i[victim_idx];
          lookup_o.thresh    = last_rank;
        end else begin
          lookup_o.slot      = free_any ? free_idx : '0;
          lookup_o.set_valid = 1'b1;
          lookup_o.inc_used  = 1'b1;
          lookup_o.thresh    = used_i;
        end
      end
    end
  end

endmodule

### rtl/core/lru_sector_cache_tags_core.sv
// Fully associative LRU tag store for disc sectors, top level.
// Depends on lsct_pkg and lsct_lookup.
//
// Input stream: s_axis_tuser carries func (0 fetch, 1 store), s_axis_tdata
// the 32-bit sector. Each transaction yields exactly one result on the
// output stream: hit, slot, written, evicted, evicted_sector.
// Configuration: cfg_data_i is the capacity (0..31, above 16 acts as 16;
// 0 disables caching); every write clears all entries. cfg_ready_o is always high.
//
// An input transaction first lands in the input register; then all 16
// tags compare and all ranks update in one pass into the output register
// together with the result, which raises m_axis_tvalid.
// Throughput is one transaction per cycle while the receiver does not
// stall; the table state written at the end of one pass is what the next
// pass sees.
//
// Reset leaves the cache empty with capacity 16. When the receiver stalls,
// the output register holds its result, the input register holds one
// more transaction, and s_axis_tready drops until the output drains.
module lru_sector_cache_tags_core
  import lsct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // [31:0] sector
  input  logic               s_axis_tuser,   // [0] func
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OUT_W-1:0]   m_axis_tdata,   // [0] hit, [4:1] slot, [5] written,
                                             // [6] evicted, [38:7] evicted_sector
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CAP_W-1:0]   cfg_data_i
);

  logic             in_valid_q;
  logic             func_q;
  sector_t          sector_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;
  logic [CAP_W-1:0] cap_q;
  cnt_t             used_q;
  sector_t          tags_q  [ENTRIES];
  logic             valid_q [ENTRIES];
  idx_t             ranks_q [ENTRIES];

  lookup_t              lk;
  logic                 advance;
  logic                 cfg_wr;
  logic [ENTRIES-1:0]   valid_vec;

  assign cfg_ready_o   = 1'b1;
  assign cfg_wr        = cfg_valid_i && cfg_ready_o;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  lsct_lookup u_lookup (
    .func_i   (func_q),
    .sector_i (sector_q),
    .tags_i   (tags_q),
    .valid_i  (valid_q),
    .ranks_i  (ranks_q),
    .used_i   (used_q),
    .cap_i    (cap_q),
    .lookup_o (lk)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q   <= s_axis_tuser;
      sector_q <= s_axis_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {1'b0, lk.ev_sector, lk.evicted, lk.written,
                     SLOT_W'(lk.slot), lk.hit};
    end
  end

  // Capacity, count, valid bits and ranks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      used_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        ranks_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      cap_q  <= cfg_data_i;
      used_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        ranks_q[i] <= '0;
      end
    end else if (advance && lk.upd) begin
      if (lk.inc_used) begin
        used_q <= used_q + cnt_t'(1);
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == lk.slot) begin
          ranks_q[i] <= '0;
          if (lk.set_valid) begin
            valid_q[i] <= 1'b1;
          end
        end else if (valid_q[i] && (CNT_W'(ranks_q[i]) < lk.thresh)) begin
          ranks_q[i] <= ranks_q[i] + idx_t'(1);
        end
      end
    end
  end

  // Tag store, no reset: a tag is compared only while its entry is valid
  always_ff @(posedge clk_i) begin
    if (!cfg_wr && advance && lk.set_tag) begin
      tags_q[lk.slot] <= sector_q;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_vec[i] = valid_q[i];
    end
  end

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (used_q == '0))
    else $error("capacity write did not clear the cache");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(used_q))
    else $error("valid entries disagree with the in-use count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(used_q) <= ENTRIES)
    else $error("in-use count above the entry count");

  a_evict_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && lk.evicted) |-> (lk.written && !lk.hit && (func_q == FUNC_STORE)))
    else $error("eviction outside a store miss");

endmodule

### verif/testbench.sv
// Self-checking bench for lru_sector_cache_tags_core: drives fetch and store
// transactions, predicts every reply with an LRU table of its own and compares.
// Depends on lsct_pkg and the core RTL only.
module testbench;
  import lsct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic    hit;
    slot_t   slot;
    logic    written;
    logic    evicted;
    sector_t ev_sector;
  } cache_reply_t;

  typedef struct {
    func_e   func;
    sector_t sector;
    int      gap;
    bit      drain;
  } sector_req_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;   // [31:0] sector
  logic             s_axis_tuser = 1'b0; // [0] func
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;        // [0] hit, [4:1] slot, [5] written,
                                         // [6] evicted, [38:7] evicted_sector
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i = CAP_RESET;

  // Predicted LRU table
  sector_t          lru_tags[ENTRIES];
  bit               lru_valid[ENTRIES];
  int               lru_rank[ENTRIES];
  int               lru_used;
  logic [CAP_W-1:0] lru_capacity;

  sector_req_t  pending_reqs[$];
  cache_reply_t replies_due[$];
  sector_req_t  tx_req;
  cache_reply_t seen_reply;
  cache_reply_t want_reply;
  int           tx_wait;
  int           rx_wait;
  int           rx_mode;
  int           tx_mode;
  int           in_flight = 0;
  int           reply_count = 0;
  int           error_count = 0;
  int           quiet_cycles = 0;

  lru_sector_cache_tags_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // 0: never idle, 1: uniform idle each time, 2: mode 1 draw one time in eight
  function automatic int draw_idle(input int mode);
    if (mode == 1) return $urandom_range(0, 16);
    if (mode == 2 && $urandom_range(0, 7) == 0) return $urandom_range(0, 16);
    return 0;
  endfunction

  function automatic void lru_clear();
    for (int i = 0; i < ENTRIES; i++) begin
      lru_tags[i]  = '0;
      lru_valid[i] = 1'b0;
      lru_rank[i]  = 0;
    end
    lru_used = 0;
  endfunction

  // Age every valid entry newer than old_rank, then put s at the front.
  function automatic void lru_promote(input int s, input int old_rank);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != s && lru_valid[i] && lru_rank[i] < old_rank) lru_rank[i]++;
    end
    lru_rank[s] = 0;
  endfunction

  function automatic cache_reply_t lru_access(input func_e func, input sector_t key);
    cache_reply_t r;
    int           cap;
    int           found;
    int           victim;
    int           s;
    r = '0;
    cap = (int'(lru_capacity) > ENTRIES) ? ENTRIES : int'(lru_capacity);
    if (cap == 0) return r;
    found = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && lru_valid[i] && lru_tags[i] == key) found = i;
    end
    if (found >= 0) begin
      lru_promote(found, lru_rank[found]);
      r.hit     = 1'b1;
      r.slot    = SLOT_W'(found);
      r.written = (func == FUNC_STORE);
    end else if (func == FUNC_STORE) begin
      victim = -1;
      if (lru_used >= cap) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (victim < 0 && lru_valid[i] && lru_rank[i] == lru_used - 1) victim = i;
        end
      end
      if (victim >= 0) begin
        r.evicted   = 1'b1;
        r.ev_sector = lru_tags[victim];
        lru_tags[victim] = key;
        lru_promote(victim, lru_rank[victim]);
        s = victim;
      end else begin
        // lowest free slot
        s = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (s < 0 && !lru_valid[i]) s = i;
        end
        lru_valid[s] = 1'b1;
        lru_tags[s]  = key;
        lru_promote(s, lru_used);
        lru_used++;
      end
      r.slot    = SLOT_W'(s);
      r.written = 1'b1;
    end
    return r;
  endfunction

  function automatic void report_error(input string what);
    if (error_count < MAX_REPORTS) $display("ERROR: %s", what);
    error_count++;
  endfunction

  // Sender: hold each transaction until taken, idle as drawn, drain if asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_reqs.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs[0].drain && (s_axis_tvalid || in_flight != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (tx_wait < pending_reqs[0].gap) begin
        tx_wait++;
        s_axis_tvalid <= 1'b0;
      end else begin
        tx_req = pending_reqs.pop_front();
        tx_wait = 0;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tx_req.sector;
        s_axis_tuser  <= tx_req.func;
      end
    end
  end

  // Receiver: stall a drawn number of cycles after each result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) rx_wait = draw_idle(rx_mode);
      else if (rx_wait > 0) rx_wait--;
      m_axis_tready <= (rx_wait == 0);
    end
  end

  // Check results first, then predict from the input taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_reply.hit       = m_axis_tdata[0];
        seen_reply.slot      = m_axis_tdata[4:1];
        seen_reply.written   = m_axis_tdata[5];
        seen_reply.evicted   = m_axis_tdata[6];
        seen_reply.ev_sector = m_axis_tdata[38:7];
        if (replies_due.size() == 0) begin
          report_error($sformatf({"result %0d with nothing pending:",
            " hit=%0b slot=%0d wr=%0b ev=%0b evs=%h"},
            reply_count, seen_reply.hit, seen_reply.slot, seen_reply.written,
            seen_reply.evicted, seen_reply.ev_sector));
        end else begin
          want_reply = replies_due.pop_front();
          if (seen_reply !== want_reply) begin
            report_error($sformatf({"result %0d: want hit=%0b slot=%0d wr=%0b ev=%0b evs=%h,",
              " got hit=%0b slot=%0d wr=%0b ev=%0b evs=%h"}, reply_count,
              want_reply.hit, want_reply.slot, want_reply.written, want_reply.evicted,
              want_reply.ev_sector, seen_reply.hit, seen_reply.slot, seen_reply.written,
              seen_reply.evicted, seen_reply.ev_sector));
          end
        end
        reply_count++;
      end
      if (s_axis_tvalid && s_axis_tready)
        replies_due.insert(replies_due.size(),
                           lru_access(func_e'(s_axis_tuser), s_axis_tdata));
      in_flight <= in_flight + int'(s_axis_tvalid && s_axis_tready)
                             - int'(m_axis_tvalid && m_axis_tready);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_req(input func_e func, input sector_t sector, input bit drain = 1'b0);
    sector_req_t r;
    r.func   = func;
    r.sector = sector;
    r.gap    = draw_idle(tx_mode);
    r.drain  = drain;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Call at a falling edge; return once every result is in.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || replies_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lru_capacity = cap;
    lru_clear();
    @(negedge clk_i);
  endtask

  // Reuse a pool a little larger than the capacity so hits and evictions mix.
  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int count);
    sector_t pool[$];
    int      eff;
    eff = (int'(cap) > ENTRIES) ? ENTRIES : int'(cap);
    repeat (eff + $urandom_range(1, 8)) pool.insert(pool.size(), sector_t'($urandom()));
    for (int n = 0; n < count; n++) begin
      queue_req(func_e'($urandom_range(0, 1)),
                ($urandom_range(0, 7) == 0) ? sector_t'($urandom())
                                            : pool[$urandom_range(0, pool.size() - 1)],
                n == count / 2);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps[10];
    caps = '{5'd31, 5'd1, 5'd16, 5'd5, 5'd0, 5'd17, 5'd8, 5'd2, 5'd24, 5'd16};
    tx_mode = 0;
    rx_mode = 0;
    lru_capacity = CAP_RESET;
    lru_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty cache, extreme keys, fetch and store hits at reset capacity
    queue_req(FUNC_FETCH, 32'h0000_0000);
    queue_req(FUNC_STORE, 32'h0000_0000);
    queue_req(FUNC_STORE, 32'hFFFF_FFFF);
    queue_req(FUNC_FETCH, 32'hFFFF_FFFF);
    queue_req(FUNC_STORE, 32'h0000_0000);
    queue_req(FUNC_FETCH, 32'h1234_5678);
    wait_drained();

    // disabled cache ignores everything
    write_capacity(5'd0);
    queue_req(FUNC_STORE, 32'h0000_0000);
    queue_req(FUNC_FETCH, 32'h0000_0000);
    wait_drained();

    // eviction order follows recency, not insertion
    write_capacity(5'd2);
    queue_req(FUNC_STORE, 32'hA5A5_A5A5);
    queue_req(FUNC_STORE, 32'h5A5A_5A5A);
    queue_req(FUNC_FETCH, 32'hA5A5_A5A5);
    queue_req(FUNC_STORE, 32'h0000_FFFF);
    queue_req(FUNC_FETCH, 32'h5A5A_5A5A);
    queue_req(FUNC_STORE, 32'hFFFF_0000);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      tx_mode = p % 3;
      rx_mode = (p + 1) % 3;
      write_capacity(caps[p]);
      run_random_phase(caps[p], 80);
      wait_drained();
    end

    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/lsct_pkg.sv
rtl/core/lsct_lookup.sv
rtl/core/lru_sector_cache_tags_core.sv
verif/testbench.sv
